@@ hw/rtl/period_capture_frequency_display_top_defines.svh @@
// Assertion macros shared by the period capture frequency display RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef PERIOD_CAPTURE_FREQUENCY_DISPLAY_TOP_DEFINES_SVH
`define PERIOD_CAPTURE_FREQUENCY_DISPLAY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define PCFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pcfd assertion failed");
// condition in one cycle implies property in the next
`define PCFD_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("pcfd assertion failed");
`else
`define PCFD_ASSERT(label, prop)
`define PCFD_ASSERT_NEXT(label, cond, prop)
`endif

`endif

@@ hw/rtl/pcfd_pkg.sv @@
// Types and constants of the period capture frequency display.
// No dependencies; used by the interfaces, the serial units and the top level.
package pcfd_pkg;

  // field widths
  localparam int TIME_W  = 16;
  localparam int CLK_W   = 25;
  localparam int HYST_W  = 8;
  localparam int FREQ_W  = 16;
  localparam int CHAR_W  = 6;
  localparam int CFG_IDX_W = 1;

  // decimal conversion of a 16-bit value needs five digits
  localparam int FREQ_DIGS = 5;
  localparam int BCD_W     = 4 * FREQ_DIGS;

  // serial step counts
  localparam int DIV_STEPS = CLK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DEC_STEPS = FREQ_W;
  localparam int DEC_CNT_W = $clog2(DEC_STEPS);

  // constants
  localparam logic [CLK_W-1:0]  CLOCK_HZ_RST = 25'd1048576;
  localparam logic [HYST_W-1:0] HYST_RST     = 8'd1;
  localparam logic [FREQ_W-1:0] FREQ_MAX     = 16'hFFFF;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 6'd32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ = 1'b0,
    REG_HYST     = 1'b1
  } cfg_reg_t;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CONV,
    ST_DONE
  } pcfd_state_t;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ hw/rtl/pcfd_in_if.sv @@
// Input channel of the period capture frequency display: one capture pair per word.
// Depends on pcfd_pkg for field widths.
interface pcfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcfd_pkg::TIME_W-1:0] start_time;
  logic [pcfd_pkg::TIME_W-1:0] end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

@@ hw/rtl/pcfd_out_if.sv @@
// Result channel of the period capture frequency display: one reading per word.
// Depends on pcfd_pkg for field widths.
interface pcfd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        updated;
  logic [pcfd_pkg::TIME_W-1:0] period;
  logic [pcfd_pkg::FREQ_W-1:0] frequency;
  logic [pcfd_pkg::CHAR_W-1:0] digit_4;
  logic [pcfd_pkg::CHAR_W-1:0] digit_3;
  logic [pcfd_pkg::CHAR_W-1:0] digit_2;
  logic [pcfd_pkg::CHAR_W-1:0] digit_1;
  logic [pcfd_pkg::CHAR_W-1:0] digit_0;

  modport source (output valid, output updated, output period, output frequency,
                  output digit_4, output digit_3, output digit_2, output digit_1,
                  output digit_0, input ready);
  modport sink   (input valid, input updated, input period, input frequency,
                  input digit_4, input digit_3, input digit_2, input digit_1,
                  input digit_0, output ready);
endinterface

@@ hw/rtl/period_capture_frequency_display_top.sv @@
// Period capture frequency display: capture pair in, period, frequency and text out.
// One word at a time. Held or empty capture: the sequencer passes straight to its done state,
// and the result loads from there once the output register is free. New reading: the 25-step
// serial divider, then the 16-step decimal shifter; a zero period skips the divider. Input reopens the cycle after
// the result loads, even while it waits, so a new word is taken only once the last has loaded.
// Reset (rst_n low, synchronous): clock_hz 1048576, hysteresis 1, kept period 0.
`include "period_capture_frequency_display_top_defines.svh"

module period_capture_frequency_display_top #(
  parameter int DIGITS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pcfd_in_if.sink                        in_if,
  pcfd_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [pcfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcfd_pkg::CLK_W-1:0]     cfg_wdata
);

  pcfd_pkg::pcfd_state_t         state_r, state_nxt;
  logic [pcfd_pkg::CLK_W-1:0]    clk_hz_r;
  logic [pcfd_pkg::HYST_W-1:0]   hyst_r;
  logic [pcfd_pkg::TIME_W-1:0]   kept_r, kept_nxt;
  logic                          upd_r, upd_nxt;
  logic [pcfd_pkg::FREQ_W-1:0]   freq_r, freq_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          load_out;
  logic                          in_acc;
  logic [pcfd_pkg::TIME_W-1:0]   period_w;
  logic [pcfd_pkg::TIME_W:0]     diff_w;
  logic [pcfd_pkg::TIME_W-1:0]   mag_w;
  logic                          upd_w;
  logic                          div_start, dec_start;
  pcfd_pkg::unit_stat_t          div_stat, dec_stat;
  logic [pcfd_pkg::FREQ_W-1:0]   div_quot;
  logic [pcfd_pkg::BCD_W-1:0]    bcd_w;
  logic [pcfd_pkg::CHAR_W-1:0]   chars_w [pcfd_pkg::FREQ_DIGS];

  logic                          o_upd_r;
  logic [pcfd_pkg::TIME_W-1:0]   o_period_r;
  logic [pcfd_pkg::FREQ_W-1:0]   o_freq_r;
  logic [pcfd_pkg::CHAR_W-1:0]   o_chars_r [pcfd_pkg::FREQ_DIGS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= pcfd_pkg::CLOCK_HZ_RST;
      hyst_r   <= pcfd_pkg::HYST_RST;
    end else if (cfg_we) begin
      unique case (pcfd_pkg::cfg_reg_t'(cfg_index))
        pcfd_pkg::REG_CLOCK_HZ: clk_hz_r <= cfg_wdata;
        pcfd_pkg::REG_HYST:     hyst_r   <= cfg_wdata[pcfd_pkg::HYST_W-1:0];
        default:                ;
      endcase
    end
  end

  // period and hysteresis decision on the incoming word
  assign in_if.ready = (state_r == pcfd_pkg::ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign period_w    = in_if.end_time - in_if.start_time;
  assign diff_w      = {1'b0, period_w} - {1'b0, kept_r};
  assign mag_w       = diff_w[pcfd_pkg::TIME_W] ? (~diff_w[pcfd_pkg::TIME_W-1:0] + 1'b1)
                                                : diff_w[pcfd_pkg::TIME_W-1:0];
  assign upd_w       = ((|in_if.start_time) || (|in_if.end_time)) &&
                       (mag_w > {{(pcfd_pkg::TIME_W-pcfd_pkg::HYST_W){1'b0}}, hyst_r});

  // sequencer
  always_comb begin
    state_nxt = state_r;
    kept_nxt  = kept_r;
    upd_nxt   = upd_r;
    freq_nxt  = freq_r;
    div_start = 1'b0;
    dec_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      pcfd_pkg::ST_IDLE: begin
        if (in_acc) begin
          upd_nxt = upd_w;
          if (!upd_w) begin
            freq_nxt  = '0;
            state_nxt = pcfd_pkg::ST_DONE;
          end else begin
            kept_nxt = period_w;
            if (period_w == '0) begin
              freq_nxt  = pcfd_pkg::FREQ_MAX;
              dec_start = 1'b1;
              state_nxt = pcfd_pkg::ST_CONV;
            end else begin
              div_start = 1'b1;
              state_nxt = pcfd_pkg::ST_DIV;
            end
          end
        end
      end
      pcfd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          freq_nxt  = div_quot;
          dec_start = 1'b1;
          state_nxt = pcfd_pkg::ST_CONV;
        end
      end
      pcfd_pkg::ST_CONV: begin
        if (dec_stat.done) begin
          state_nxt = pcfd_pkg::ST_DONE;
        end
      end
      pcfd_pkg::ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = pcfd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pcfd_pkg::ST_IDLE;
    endcase
  end

  // serial divider
  pcfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clk_hz_r),
    .divisor  (period_w),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // serial decimal converter
  pcfd_dec u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dec_start),
    .value (freq_nxt),
    .stat  (dec_stat),
    .bcd   (bcd_w)
  );

  // characters: blank above the leading digit (all blank for zero), above DIGITS, or when held
  always_comb begin
    logic higher;
    higher = 1'b0;
    for (int k = pcfd_pkg::FREQ_DIGS - 1; k >= 0; k--) begin
      higher = higher | (|bcd_w[4*k +: 4]);
      chars_w[k] = (upd_r && higher && (k < DIGITS))
                   ? pcfd_pkg::CHAR_ZERO + {2'b00, bcd_w[4*k +: 4]}
                   : pcfd_pkg::CHAR_BLANK;
    end
  end

  // output word register
  assign out_valid_nxt = load_out ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcfd_pkg::ST_IDLE;
      kept_r      <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    freq_r <= freq_nxt;
    if (load_out) begin
      o_upd_r    <= upd_r;
      o_period_r <= kept_r;
      o_freq_r   <= freq_r;
      o_chars_r  <= chars_w;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.updated   = o_upd_r;
  assign out_if.period    = o_period_r;
  assign out_if.frequency = o_freq_r;
  assign out_if.digit_4   = o_chars_r[4];
  assign out_if.digit_3   = o_chars_r[3];
  assign out_if.digit_2   = o_chars_r[2];
  assign out_if.digit_1   = o_chars_r[1];
  assign out_if.digit_0   = o_chars_r[0];

  // checks
  `PCFD_ASSERT_NEXT(a_one_word_in_flight, in_acc, !in_if.ready)
  `PCFD_ASSERT_NEXT(a_kept_only_on_accept, !in_acc, $stable(kept_r))
  `PCFD_ASSERT(a_div_done_in_div, div_stat.done |-> (state_r == pcfd_pkg::ST_DIV))
  `PCFD_ASSERT(a_held_is_blank, (out_if.valid && !out_if.updated) |-> (out_if.frequency == '0 && out_if.digit_0 == pcfd_pkg::CHAR_BLANK))

endmodule

@@ hw/rtl/pcfd_div.sv @@
// Bit-serial restoring divider: clock rate over period, one quotient bit per cycle.
// Depends on pcfd_pkg; the quotient saturates to the frequency width.
module pcfd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pcfd_pkg::CLK_W-1:0]   dividend,
  input  logic [pcfd_pkg::TIME_W-1:0]  divisor,
  output pcfd_pkg::unit_stat_t         stat,
  output logic [pcfd_pkg::FREQ_W-1:0]  quotient
);

  logic [pcfd_pkg::CLK_W-1:0]     dvd_r, dvd_nxt;
  logic [pcfd_pkg::TIME_W-1:0]    dsr_r, dsr_nxt;
  logic [pcfd_pkg::TIME_W-1:0]    rem_r, rem_nxt;
  logic [pcfd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [pcfd_pkg::TIME_W:0]      rem_sh;
  logic                           fits;

  // trial subtract of the divisor from the shifted remainder
  assign rem_sh = {rem_r, dvd_r[pcfd_pkg::CLK_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // quotient bits enter at the bottom as dividend bits leave the top
      rem_nxt = fits ? pcfd_pkg::TIME_W'(rem_sh - {1'b0, dsr_r})
                     : rem_sh[pcfd_pkg::TIME_W-1:0];
      dvd_nxt = {dvd_r[pcfd_pkg::CLK_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pcfd_pkg::DIV_CNT_W'(pcfd_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // saturate the wide quotient
  assign quotient = (|dvd_r[pcfd_pkg::CLK_W-1:pcfd_pkg::FREQ_W]) ? pcfd_pkg::FREQ_MAX
                                                              : dvd_r[pcfd_pkg::FREQ_W-1:0];

endmodule

@@ hw/rtl/pcfd_dec.sv @@
// Serial binary to decimal converter: shift-and-add-3, one binary bit per cycle.
// Depends on pcfd_pkg; yields five packed decimal digits.
module pcfd_dec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcfd_pkg::FREQ_W-1:0] value,
  output pcfd_pkg::unit_stat_t        stat,
  output logic [pcfd_pkg::BCD_W-1:0]  bcd
);

  logic [pcfd_pkg::FREQ_W-1:0]    bin_r, bin_nxt;
  logic [pcfd_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [pcfd_pkg::DEC_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [pcfd_pkg::BCD_W-1:0]     adj;

  // digits at five or more get three added before the shift
  always_comb begin
    for (int k = 0; k < pcfd_pkg::FREQ_DIGS; k++) begin
      adj[4*k +: 4] = (bcd_r[4*k +: 4] >= 4'd5) ? bcd_r[4*k +: 4] + 4'd3 : bcd_r[4*k +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[pcfd_pkg::BCD_W-2:0], bin_r[pcfd_pkg::FREQ_W-1]};
      bin_nxt = {bin_r[pcfd_pkg::FREQ_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pcfd_pkg::DEC_CNT_W'(pcfd_pkg::DEC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule
